// ===== hdl/assert_macros.svh =====
// Assertion helpers for the expression evaluator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ltre_pkg.sv =====
package ltre_pkg;

  localparam int STACK_DEPTH_DEF = 64;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNBAL = 2'd1,
    ST_DIV0  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_DIV,
    S_FINAL,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;     // latch input beat, do char work
    logic apply;    // apply pending op
    logic div_go;   // start multiply/divide unit
    logic div_done; // write multiply/divide result
    logic fin;      // compute output into the result register
    logic clear;    // after result taken
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_op;
    logic is_last;
    logic need_div; // pending op is multiply, or divide with nonzero operand
    logic div_busy;
  } stat_t;

endpackage

// ===== hdl/ltre_ctrl.sv =====
module ltre_ctrl
  import ltre_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   fin_phase_r, fin_phase_nxt; // divide belongs to end of expression

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fin_phase_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fin_phase_r <= fin_phase_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    fin_phase_nxt = fin_phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          fin_phase_nxt = 1'b0;
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        // an operator applies first, then the end of expression applies
        if (stat.is_op && !fin_phase_r) begin
          state_nxt = stat.need_div ? S_DIV : (stat.is_last ? S_FINAL : S_IDLE);
        end else if (stat.is_last) begin
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          if (fin_phase_r) state_nxt = S_OUT;
          else if (stat.is_last) state_nxt = S_FINAL;
          else state_nxt = S_IDLE;
        end
      end
      S_FINAL: begin
        fin_phase_nxt = 1'b1;
        state_nxt = stat.need_div ? S_DIV : S_OUT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
      end
      S_APPLY: begin
        if (stat.is_op) begin
          cmd.apply  = !stat.need_div;
          cmd.div_go = stat.need_div;
        end
      end
      S_DIV:   cmd.div_done = !stat.div_busy;
      S_FINAL: begin
        cmd.apply  = !stat.need_div;
        cmd.div_go = stat.need_div;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        cmd.clear  = out_tready;
      end
      default: ;
    endcase
    cmd.fin = (state_r == S_FINAL && !stat.need_div) ||
              (state_r == S_DIV && fin_phase_r && !stat.div_busy);
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_rdy_excl, clk, rst_n, in_tready, !out_tvalid, "ready while result shown")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid,
               "result dropped")
  `ASSERT_IMPL(a_div_cmd, clk, rst_n, cmd.div_go, !cmd.apply, "divide and apply together")

endmodule

// ===== hdl/ltre_div.sv =====
module ltre_div
  import ltre_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        mul_mode,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [63:0] quotient   // product in multiply mode
);

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] dsr_r, dsr_nxt;
  logic        neg_r;
  logic        mode_mul_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [64:0] trial;

  // one bit per cycle: shift-add multiply, or restoring divide on magnitudes
  always_comb begin
    trial = {rem_r, quo_r[63]} - {1'b0, dsr_r};
    if (mode_mul_r) begin
      rem_nxt = quo_r[0] ? (rem_r + dsr_r) : rem_r;
      quo_nxt = {1'b0, quo_r[63:1]};
      dsr_nxt = {dsr_r[62:0], 1'b0};
    end else begin
      rem_nxt = trial[64] ? {rem_r[62:0], quo_r[63]} : trial[63:0];
      quo_nxt = {quo_r[62:0], ~trial[64]};
      dsr_nxt = dsr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd64;
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 7'd1;
      busy_r <= (cnt_r != 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_mul_r <= mul_mode;
      rem_r      <= '0;
      if (mul_mode) begin
        quo_r <= dividend;
        dsr_r <= divisor;
        neg_r <= 1'b0;
      end else begin
        quo_r <= dividend[63] ? (64'd0 - dividend) : dividend;
        dsr_r <= divisor[63] ? (64'd0 - divisor) : divisor;
        neg_r <= dividend[63] ^ divisor[63];
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      dsr_r <= dsr_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = mode_mul_r ? rem_r : (neg_r ? (64'd0 - quo_r) : quo_r);

endmodule

// ===== hdl/ltre_dp.sv =====
module ltre_dp
  import ltre_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  char_in,
  input  logic        last_in,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic [63:0] value,
  output logic [1:0]  status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PW = $clog2(STACK_DEPTH + 1);

  logic [7:0]  ch_r;
  logic        last_r;
  logic [63:0] res_r, num_r, val_r;
  op_t         op_r, op_code;
  logic [PW-1:0] sp_r;
  logic        unbal_r, div0_r;
  logic [1:0]  status_r;
  logic [1:0]  stack_mem [STACK_DEPTH];
  logic [1:0]  top_r;
  logic        is_open, is_close, is_op;
  logic [1:0]  kind;
  logic        div_busy;
  logic [63:0] quo;
  logic [63:0] mul_r;
  logic [63:0] digit;
  logic [63:0] fin_value;
  logic        apply_char, fin_pend, stack_mem_we, first_r;

  // character classes of the latched beat
  always_comb begin
    is_open = 1'b0; is_close = 1'b0; is_op = 1'b0; kind = 2'd0; op_code = OP_LOAD;
    unique case (ch_r)
      CH_LBRC:  begin is_open = 1'b1;  kind = 2'd0; end
      CH_LBRK:  begin is_open = 1'b1;  kind = 2'd1; end
      CH_LPAR:  begin is_open = 1'b1;  kind = 2'd2; end
      CH_RBRC:  begin is_close = 1'b1; kind = 2'd0; end
      CH_RBRK:  begin is_close = 1'b1; kind = 2'd1; end
      CH_RPAR:  begin is_close = 1'b1; kind = 2'd2; end
      CH_PLUS:  begin is_op = 1'b1; op_code = OP_ADD; end
      CH_MINUS: begin is_op = 1'b1; op_code = OP_SUB; end
      CH_STAR:  begin is_op = 1'b1; op_code = OP_MUL; end
      CH_SLASH: begin is_op = 1'b1; op_code = OP_DIV; end
      default: ;
    endcase
  end

  assign stat.is_op    = is_op;
  assign stat.is_last  = last_r;
  assign stat.need_div = (op_r == OP_MUL) || ((op_r == OP_DIV) && (num_r != 64'd0));
  assign stat.div_busy = div_busy;

  // top of stack read, registered, one address back from the pointer
  always_ff @(posedge clk) begin
    if (sp_r != '0) top_r <= stack_mem[AW'(sp_r - PW'(1))];
    else top_r <= 2'd0;
  end

  // latch beat; digit product registered ahead of the update
  assign digit = {56'd0, char_in - CH_ZERO};
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ch_r   <= char_in;
      last_r <= last_in;
      mul_r  <= num_r * 64'd10 + digit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r    <= '0;
      unbal_r <= 1'b0;
      div0_r  <= 1'b0;
      op_r    <= OP_LOAD;
      res_r   <= '0;
      num_r   <= '0;
    end else if (cmd.clear) begin
      sp_r    <= '0;
      unbal_r <= 1'b0;
      div0_r  <= 1'b0;
      op_r    <= OP_LOAD;
      res_r   <= '0;
      num_r   <= '0;
    end else begin
      // char work happens in the cycle after the beat is latched
      if (cmd.apply || cmd.div_go) begin
        unique case (op_r)
          OP_ADD: res_r <= res_r + num_r;
          OP_SUB: res_r <= res_r - num_r;
          OP_MUL: ; // product comes back from the multi-cycle unit
          OP_DIV: if (num_r == 64'd0) begin
            div0_r <= 1'b1;
            res_r  <= '0;
          end
          default: res_r <= num_r;
        endcase
        num_r <= '0;
        if (is_op && !cmd.fin && !fin_pend) op_r <= op_code;
      end
      if (cmd.div_done) res_r <= quo;
      if (apply_char) begin
        if (is_open) begin
          if (sp_r < PW'(STACK_DEPTH)) begin
            sp_r <= sp_r + PW'(1);
          end else unbal_r <= 1'b1;
        end else if (is_close) begin
          if (sp_r == '0) unbal_r <= 1'b1;
          else begin
            sp_r <= sp_r - PW'(1);
            if (top_r != kind) unbal_r <= 1'b1;
          end
        end else if (!is_op) begin
          num_r <= mul_r;
        end
      end
      if (cmd.fin && sp_r != '0) unbal_r <= 1'b1;
    end
  end

  // char effects apply once per beat: in the first cycle after latching
  always_ff @(posedge clk) begin
    if (!rst_n) first_r <= 1'b0;
    else first_r <= cmd.take;
  end
  assign apply_char = first_r;
  assign fin_pend   = !first_r;
  always_comb stack_mem_we = apply_char && is_open && (sp_r < PW'(STACK_DEPTH));

  always_ff @(posedge clk) begin
    if (stack_mem_we) stack_mem[AW'(sp_r)] <= kind;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      if (unbal_r || sp_r != '0) begin
        val_r <= '0; status_r <= ST_UNBAL;
      end else if (div0_r || (op_r == OP_DIV && num_r == 64'd0 && !cmd.div_done)) begin
        val_r <= '0; status_r <= ST_DIV0;
      end else begin
        val_r    <= cmd.div_done ? quo : fin_value;
        status_r <= ST_OK;
      end
    end
  end

  always_comb begin
    unique case (op_r)
      OP_ADD:  fin_value = res_r + num_r;
      OP_SUB:  fin_value = res_r - num_r;
      OP_MUL:  fin_value = '0;
      OP_DIV:  fin_value = '0;
      default: fin_value = num_r;
    endcase
  end

  ltre_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .mul_mode (op_r == OP_MUL),
    .dividend (res_r),
    .divisor  (num_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign value  = val_r;
  assign status = status_r;

endmodule

// ===== hdl/left_to_right_expression_evaluator.sv =====
// Left-to-right expression evaluator. One character per input beat; the beat
// with tlast closes the expression and yields one result beat (value, status),
// other beats yield none. Brackets are checked on a STACK_DEPTH-entry stack;
// + - * / apply left to right without precedence, wrapping at 64 bits. A
// character beat is latched, then worked; an operator whose pending operation is a
// multiply, or a divide by a nonzero value, also waits on the one-bit-per-cycle
// shift-add / restoring unit, and the closing beat adds the final apply, a
// possible multiply or divide and the result register.
// One expression character is worked at a time; the next beat is taken once
// the previous one is finished and any result has been taken.
module left_to_right_expression_evaluator
  import ltre_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_in[7:0]
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // value[63:0], status[65:64], zero fill
);

  cmd_t        cmd;
  stat_t       stat;
  logic [63:0] value;
  logic [1:0]  status;

  ltre_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ltre_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .char_in (in_tdata),
    .last_in (in_tlast),
    .cmd     (cmd),
    .stat    (stat),
    .value   (value),
    .status  (status)
  );

  assign out_tdata = {6'd0, status, value};

endmodule
